[design/u8u16_pkg.sv]
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

	localparam int unsigned CmdqDepth = 4;
	localparam int unsigned CmdqPtrW  = $clog2(CmdqDepth);
	localparam int unsigned CmdqCntW  = $clog2(CmdqDepth + 1);

	localparam logic [20:0] MaxCodePoint  = 21'h10ffff;
	localparam logic [20:0] SurrogateLo   = 21'h00d800;
	localparam logic [20:0] SurrogateHi   = 21'h00dfff;
	localparam logic [20:0] SupplBase     = 21'h010000;
	localparam logic [20:0] MinTwoByte    = 21'h000080;
	localparam logic [20:0] MinThreeByte  = 21'h000800;
	localparam logic [20:0] MinFourByte   = 21'h010000;
	localparam logic [15:0] HighSurrBase  = 16'hd800;
	localparam logic [15:0] LowSurrBase   = 16'hdc00;
	localparam logic [15:0] BmpMax        = 16'hffff;
	localparam logic [9:0]  TenBitMask    = 10'h3ff;

	localparam logic [7:0] LeadMask2 = 8'he0;
	localparam logic [7:0] LeadMask3 = 8'hf0;
	localparam logic [7:0] LeadMask4 = 8'hf8;
	localparam logic [7:0] LeadPat2  = 8'hc0;
	localparam logic [7:0] LeadPat3  = 8'he0;
	localparam logic [7:0] LeadPat4  = 8'hf0;
	localparam logic [7:0] ContMask  = 8'hc0;
	localparam logic [7:0] ContPat   = 8'h80;
	localparam logic [7:0] AsciiMax  = 8'h7f;
	localparam logic [5:0] ContBits  = 6'h3f;

	localparam logic [2:0] SeqLen2 = 3'd2;
	localparam logic [2:0] SeqLen3 = 3'd3;
	localparam logic [2:0] SeqLen4 = 3'd4;

	typedef enum logic [1:0] {
		CMD_UNIT,
		CMD_PAIR,
		CMD_STATUS
	} cmd_kind_t;

	// one queued job for the back end
	typedef struct packed {
		cmd_kind_t   kind;
		logic [20:0] scalar;
		logic        last;
	} cmd_t;

endpackage

[design/utf8_to_utf16_transcoder_core.sv]
// top level of the utf-8 to utf-16 transcoder with validation
//
//  channel   | direction | handshake    | payload
//  ----------+-----------+--------------+--------------------------------------------
//  byte in   | input     | push / full  | data_byte[7:0], end_of_string
//  result    | output    | empty / pop  | code_unit[15:0], unit_valid, decode_error, last
//
// one byte is taken per cycle while the command queue has room; the decoder
// state (pending continuation count, partial code point) is updated in that cycle
// a byte's result passes through a queue entry and then the output register
// before it can be popped (queue write, then output register load)
// a surrogate pair occupies the output register for two transfers, so the
// sustained rate is one byte per cycle; a reader that pops more slowly than
// results are made backs up into the queue and raises full
// arst_n clears the decoder state, the queue pointers and the output valid flag
// full depends only on queue occupancy; pop stalls drain through the output register
module utf8_to_utf16_transcoder_core
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] code_unit,
	output logic        unit_valid,
	output logic        decode_error,
	output logic        last
);

	logic accept;
	logic cmd_wr;
	cmd_t cmd_in;
	logic q_full;
	logic cmd_take;
	logic cmd_avail;
	cmd_t cmd_out;

	// byte transfer happens whenever the queue can absorb a possible command
	assign full   = q_full;
	assign accept = push && !q_full;

	// front end: sequence collection, range and surrogate checks, error tracking
	u8u16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.cmd_valid     (cmd_wr),
		.cmd           (cmd_in)
	);

	// decouples decoding from unit output so either side can stall
	u8u16_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_wr && accept),
		.wr_cmd   (cmd_in),
		.full     (q_full),
		.rd_en    (cmd_take),
		.rd_avail (cmd_avail),
		.rd_cmd   (cmd_out)
	);

	// back end: utf-16 encoding and result transfer
	u8u16_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (cmd_avail),
		.cmd          (cmd_out),
		.cmd_take     (cmd_take),
		.empty        (empty),
		.pop          (pop),
		.code_unit    (code_unit),
		.unit_valid   (unit_valid),
		.decode_error (decode_error),
		.last         (last)
	);

endmodule

[design/u8u16_front.sv]
// byte decoder: collects utf-8 sequences, validates them, issues commands
module u8u16_front
	import u8u16_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	logic [1:0]  rem_q;
	logic [20:0] cp_q;
	logic [2:0]  len_q;
	logic        err_q;

	logic [1:0]  rem_n;
	logic [20:0] cp_n;
	logic [2:0]  len_n;
	logic        err_n;
	logic        complete;
	logic [20:0] cp_done;
	logic [20:0] min_cp;

	always_comb begin
		case (len_q)
			SeqLen2: min_cp = MinTwoByte;
			SeqLen3: min_cp = MinThreeByte;
			SeqLen4: min_cp = MinFourByte;
			default: min_cp = '0;
		endcase
	end

	always_comb begin
		rem_n    = rem_q;
		cp_n     = cp_q;
		len_n    = len_q;
		err_n    = err_q;
		complete = 1'b0;
		cp_done  = cp_q;
		if (!err_q) begin
			if (rem_q == 2'd0) begin
				if (data_byte <= AsciiMax) begin
					cp_done  = {13'd0, data_byte};
					complete = 1'b1;
				end else if ((data_byte & LeadMask2) == LeadPat2) begin
					cp_n  = {16'd0, data_byte[4:0]};
					len_n = SeqLen2;
					rem_n = 2'd1;
				end else if ((data_byte & LeadMask3) == LeadPat3) begin
					cp_n  = {17'd0, data_byte[3:0]};
					len_n = SeqLen3;
					rem_n = 2'd2;
				end else if ((data_byte & LeadMask4) == LeadPat4) begin
					cp_n  = {18'd0, data_byte[2:0]};
					len_n = SeqLen4;
					rem_n = 2'd3;
				end else begin
					err_n = 1'b1;
				end
			end else if ((data_byte & ContMask) != ContPat) begin
				err_n = 1'b1;
			end else begin
				cp_n  = {cp_q[14:0], data_byte[5:0] & ContBits};
				rem_n = rem_q - 2'd1;
				if (rem_n == 2'd0) begin
					cp_done = cp_n;
					if (cp_n < min_cp || cp_n > MaxCodePoint ||
						(cp_n >= SurrogateLo && cp_n <= SurrogateHi)) begin
						err_n = 1'b1;
					end else begin
						complete = 1'b1;
					end
					cp_n  = '0;
					len_n = '0;
				end
			end
		end
		// string cut off inside a sequence
		if (end_of_string && rem_n != 2'd0) begin
			err_n = 1'b1;
		end
	end

	always_comb begin
		cmd_valid   = 1'b0;
		cmd.kind    = CMD_UNIT;
		cmd.scalar  = cp_done;
		cmd.last    = end_of_string;
		if (end_of_string && err_n) begin
			cmd_valid = 1'b1;
			cmd.kind  = CMD_STATUS;
		end else if (complete) begin
			cmd_valid = 1'b1;
			cmd.kind  = (cp_done > {5'd0, BmpMax}) ? CMD_PAIR : CMD_UNIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cp_q  <= '0;
			len_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				rem_q <= '0;
				cp_q  <= '0;
				len_q <= '0;
				err_q <= 1'b0;
			end else begin
				rem_q <= rem_n;
				cp_q  <= complete ? '0 : cp_n;
				len_q <= complete ? '0 : len_n;
				err_q <= err_n;
			end
		end
	end

endmodule

[design/u8u16_cmdq.sv]
// short command queue between decoder and unit generator
module u8u16_cmdq
	import u8u16_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic rd_avail,
	output cmd_t rd_cmd
);

	cmd_t                entry_q [CmdqDepth];
	logic [CmdqPtrW-1:0] wr_ptr_q;
	logic [CmdqPtrW-1:0] rd_ptr_q;
	logic [CmdqCntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full     = (count_q == CmdqCntW'(CmdqDepth));
	assign rd_avail = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_avail;

	function automatic logic [CmdqPtrW-1:0] ptr_inc(input logic [CmdqPtrW-1:0] p);
		ptr_inc = (p == CmdqPtrW'(CmdqDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/u8u16_back.sv]
// unit generator: turns commands into utf-16 results, splits surrogate pairs
module u8u16_back
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  cmd_t        cmd,
	output logic        cmd_take,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] code_unit,
	output logic        unit_valid,
	output logic        decode_error,
	output logic        last
);

	logic        out_valid_q;
	logic [15:0] code_q;
	logic        uv_q;
	logic        err_q;
	logic        last_q;
	logic        pend_q;
	logic [15:0] pend_code_q;
	logic        pend_last_q;

	logic        can_load;
	logic [20:0] v_full;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;

	assign can_load = !out_valid_q || pop;
	assign cmd_take = can_load && !pend_q && cmd_avail;

	assign v_full  = cmd.scalar - SupplBase;
	assign hi_unit = HighSurrBase + {6'd0, v_full[19:10]};
	assign lo_unit = LowSurrBase + {6'd0, v_full[9:0] & TenBitMask};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (can_load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (cmd_avail) begin
				out_valid_q <= 1'b1;
				pend_q      <= (cmd.kind == CMD_PAIR);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_q) begin
				code_q <= pend_code_q;
				uv_q   <= 1'b1;
				err_q  <= 1'b0;
				last_q <= pend_last_q;
			end else if (cmd_avail) begin
				case (cmd.kind)
					CMD_UNIT: begin
						code_q <= cmd.scalar[15:0];
						uv_q   <= 1'b1;
						err_q  <= 1'b0;
						last_q <= cmd.last;
					end
					CMD_PAIR: begin
						code_q      <= hi_unit;
						uv_q        <= 1'b1;
						err_q       <= 1'b0;
						last_q      <= 1'b0;
						pend_code_q <= lo_unit;
						pend_last_q <= cmd.last;
					end
					default: begin
						code_q <= '0;
						uv_q   <= 1'b0;
						err_q  <= 1'b1;
						last_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign empty        = !out_valid_q;
	assign code_unit    = code_q;
	assign unit_valid   = uv_q;
	assign decode_error = err_q;
	assign last         = last_q;

endmodule
